@@ hdl/hst_pkg.sv @@
package hst_pkg;

  localparam int TABLE_SLOTS  = 128;
  localparam int SLOT_W       = $clog2(TABLE_SLOTS);
  localparam int ID_W         = 64;
  localparam int STATUS_W     = 8;
  localparam int SLOT_FIELD_W = 7;
  localparam int ACTION_W     = 2;
  // weighted byte sum: at most 255 * 98, fits 15 bits
  localparam int SUM_W        = 15;

  localparam logic [STATUS_W-1:0] EMPTY_STATUS = 8'hEE;

  localparam logic [4:0] HASH_WEIGHT [8] = '{5'd3, 5'd5, 5'd7, 5'd11,
                                             5'd13, 5'd17, 5'd19, 5'd23};

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_WRITE  = 2'd2
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0]     action;
    logic [ID_W-1:0]         id;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [STATUS_W-1:0]     status_in;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic [SLOT_FIELD_W-1:0] slot_out;
    logic [STATUS_W-1:0]     status_out;
  } rsp_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_INSERT,
    WR_DELETE,
    WR_STATUS
  } wr_op_t;

  typedef struct packed {
    wr_op_t              op;
    logic [SLOT_W-1:0]   addr;
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
  } wr_t;

  typedef struct packed {
    logic                present;
    logic                deleted;
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
  } rd_t;

  typedef struct packed {
    logic load;
    logic step;
  } addr_ctl_t;

  // home slot: prime-weighted sum of the id bytes, modulo the table size
  function automatic logic [SLOT_W-1:0] home_of(input logic [ID_W-1:0] key);
    logic [SUM_W-1:0] sum;
    sum = '0;
    for (int b = 0; b < 8; b++) begin
      sum = sum + SUM_W'(HASH_WEIGHT[b]) * SUM_W'(key[8*b +: 8]);
    end
    return SLOT_W'(sum % TABLE_SLOTS);
  endfunction

endpackage

@@ hdl/hst_store.sv @@
module hst_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [hst_pkg::SLOT_W-1:0] rd_addr,
  input  hst_pkg::wr_t              wr,
  output hst_pkg::rd_t              rd
);

  logic [hst_pkg::ID_W-1:0]     id_ram     [hst_pkg::TABLE_SLOTS];
  logic [hst_pkg::STATUS_W-1:0] status_ram [hst_pkg::TABLE_SLOTS];

  // per-slot flags; status_valid low means the status reads as empty
  logic [hst_pkg::TABLE_SLOTS-1:0] present;
  logic [hst_pkg::TABLE_SLOTS-1:0] deleted;
  logic [hst_pkg::TABLE_SLOTS-1:0] status_valid;

  logic [hst_pkg::ID_W-1:0]     id_q;
  logic [hst_pkg::STATUS_W-1:0] status_q;
  logic                         present_q;
  logic                         deleted_q;
  logic                         status_valid_q;

  always_ff @(posedge clk) begin
    if (wr.op == hst_pkg::WR_INSERT) begin
      id_ram[wr.addr] <= wr.id;
    end
    id_q <= id_ram[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.op == hst_pkg::WR_STATUS) begin
      status_ram[wr.addr] <= wr.status;
    end
    status_q <= status_ram[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present      <= '0;
      deleted      <= '0;
      status_valid <= '0;
    end else begin
      unique case (wr.op)
        hst_pkg::WR_INSERT: begin
          present[wr.addr] <= 1'b1;
          deleted[wr.addr] <= 1'b0;
        end
        hst_pkg::WR_DELETE: begin
          present[wr.addr]      <= 1'b0;
          deleted[wr.addr]      <= 1'b1;
          status_valid[wr.addr] <= 1'b0;
        end
        hst_pkg::WR_STATUS: begin
          status_valid[wr.addr] <= 1'b1;
        end
        hst_pkg::WR_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    present_q      <= present[rd_addr];
    deleted_q      <= deleted[rd_addr];
    status_valid_q <= status_valid[rd_addr];
  end

  assign rd.present = present_q;
  assign rd.deleted = deleted_q;
  assign rd.id      = id_q;
  assign rd.status  = status_valid_q ? status_q : hst_pkg::EMPTY_STATUS;

endmodule

@@ hdl/hst_addr.sv @@
module hst_addr (
  input  logic                       clk,
  input  logic                       rst,
  input  hst_pkg::addr_ctl_t         ctl,
  input  logic [hst_pkg::ID_W-1:0]   id,
  output logic [hst_pkg::SLOT_W-1:0] idx,
  output logic                       last
);

  localparam logic [hst_pkg::SLOT_W-1:0] K_LAST = hst_pkg::SLOT_W'(hst_pkg::TABLE_SLOTS - 1);
  localparam logic [hst_pkg::SLOT_W:0]   SLOTS  = (hst_pkg::SLOT_W+1)'(hst_pkg::TABLE_SLOTS);

  logic [hst_pkg::SLOT_W-1:0] home;
  logic [hst_pkg::SLOT_W-1:0] stride;
  logic [hst_pkg::SLOT_W-1:0] k;
  logic [hst_pkg::SLOT_W:0]   sum;
  logic [hst_pkg::SLOT_W-1:0] idx_next;

  // single add with one conditional subtract: both terms are below the size
  assign sum      = {1'b0, idx} + {1'b0, stride};
  assign idx_next = (sum >= SLOTS) ? hst_pkg::SLOT_W'(sum - SLOTS) : sum[hst_pkg::SLOT_W-1:0];

  // next probe would wrap to home or exhaust the count
  assign last = (k == K_LAST) || (idx_next == home);

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (ctl.load) begin
      k <= '0;
    end else if (ctl.step) begin
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      home   <= hst_pkg::home_of(id);
      idx    <= hst_pkg::home_of(id);
      stride <= hst_pkg::SLOT_W'(id[7:0] % hst_pkg::TABLE_SLOTS);
    end else if (ctl.step) begin
      idx <= idx_next;
    end
  end

endmodule

@@ hdl/hashed_status_table.sv @@
// Hashed status table: open-addressed store of 128 slots keyed by 64-bit
// request ids, each slot holding an id and a status byte. A request is taken
// when start is high and busy is low; its single result appears on result for
// exactly one cycle with done high, and must be taken then - there is no
// back-pressure on the result side. Busy drops in the done cycle, so the next
// request may be issued alongside the result.
// Insert and delete hash the id in the accept cycle, then walk the probe
// sequence (home + k * low id byte) one slot at a time. Each probe is a
// registered read of the slot store, then the compare, and the single probe
// adder steps to the next slot. A request settles after 1 to 128 probes;
// write-status and the unused action code go straight to the write-status
// state. Slot flags are flip-flops cleared by reset, so the table is usable
// the cycle after reset with no clearing pass. Insert takes the first free
// or deleted slot and does not check for duplicates; delete stops at a
// never-used slot. Failures return ok low with slot_out and status_out zero.
module hashed_status_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  hst_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output hst_pkg::rsp_t result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WSTAT
  } state_t;

  state_t state;

  hst_pkg::req_t      req_q;
  hst_pkg::addr_ctl_t addr_ctl;
  hst_pkg::wr_t       wr;
  hst_pkg::rd_t       rd;

  logic [hst_pkg::SLOT_W-1:0] idx;
  logic                       last;
  logic                       accept;
  logic                       finish;
  hst_pkg::rsp_t              rsp_next;
  logic                       probe_more;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // probe address generator: hash on accept, one stride step per probe
  hst_addr u_addr (
    .clk  (clk),
    .rst  (rst),
    .ctl  (addr_ctl),
    .id   (request.id),
    .idx  (idx),
    .last (last)
  );

  // slot store: id and status memories plus reset-cleared flags
  hst_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (idx),
    .wr      (wr),
    .rd      (rd)
  );

  // request held for the whole walk
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
  end

  always_comb begin
    addr_ctl.load = accept;
    addr_ctl.step = 1'b0;
    wr.op         = hst_pkg::WR_NONE;
    wr.addr       = idx;
    wr.id         = req_q.id;
    wr.status     = req_q.status_in;
    finish        = 1'b0;
    rsp_next      = '0;
    probe_more    = 1'b0;

    unique case (state) inside
      S_CHECK: begin
        if (req_q.action == hst_pkg::ACT_INSERT) begin
          if (!rd.present) begin
            // free or deleted slot: claim it
            wr.op             = hst_pkg::WR_INSERT;
            finish            = 1'b1;
            rsp_next.ok       = 1'b1;
            rsp_next.slot_out = hst_pkg::SLOT_FIELD_W'(idx);
          end else begin
            probe_more = 1'b1;
          end
        end else begin
          if (rd.present && (rd.id == req_q.id)) begin
            wr.op               = hst_pkg::WR_DELETE;
            finish              = 1'b1;
            rsp_next.ok         = 1'b1;
            rsp_next.slot_out   = hst_pkg::SLOT_FIELD_W'(idx);
            rsp_next.status_out = rd.status;
          end else if (!rd.present && !rd.deleted) begin
            // never-used slot ends a delete search
            finish = 1'b1;
          end else begin
            probe_more = 1'b1;
          end
        end
        if (probe_more) begin
          if (last) begin
            finish = 1'b1;
          end else begin
            addr_ctl.step = 1'b1;
          end
        end
      end
      S_WSTAT: begin
        finish  = 1'b1;
        wr.addr = hst_pkg::SLOT_W'(req_q.slot);
        if ((req_q.action == hst_pkg::ACT_WRITE) &&
            (int'(req_q.slot) < hst_pkg::TABLE_SLOTS)) begin
          wr.op             = hst_pkg::WR_STATUS;
          rsp_next.ok       = 1'b1;
          rsp_next.slot_out = req_q.slot;
        end
      end
      S_IDLE, S_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= finish;
      if (finish) begin
        result <= rsp_next;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if ((request.action == hst_pkg::ACT_INSERT) ||
                (request.action == hst_pkg::ACT_DELETE)) begin
              state <= S_READ;
            end else begin
              state <= S_WSTAT;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= finish ? S_IDLE : S_READ;
        end
        S_WSTAT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result only follows a cycle in which the block was working
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  // an accepted request always makes the block busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  // failures carry no slot and no status
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.slot_out == '0) && (result.status_out == '0))
    else $error("failed request returned a slot or status");
`endif

endmodule
